[hdl/tnh_pkg.sv]
// tnh_pkg: shared widths, entry and compare types for the top-n heap tracker
// no dependencies

package tnh_pkg;

    localparam int VALUE_W = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W = 4;
    localparam int HEAP_SIZE_DEF = 16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic take_right;
        logic stop;
    } pick_t;

endpackage

[hdl/tnh_heap_mem.sv]
// tnh_heap_mem: heap entry storage, one write port and two registered read ports
// depends on tnh_pkg for entry_t

module tnh_heap_mem #(
    parameter int DEPTH = tnh_pkg::HEAP_SIZE_DEF,
    parameter int AW = $clog2(tnh_pkg::HEAP_SIZE_DEF)
) (
    input  logic clk,
    input  logic we,
    input  logic [AW-1:0] waddr,
    input  tnh_pkg::entry_t wdata,
    input  logic [AW-1:0] raddr_a,
    output tnh_pkg::entry_t rdata_a,
    input  logic [AW-1:0] raddr_b,
    output tnh_pkg::entry_t rdata_b
);

    tnh_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hdl/tnh_pick.sv]
// tnh_pick: chooses the child to descend to and decides whether the sift stops
// depends on tnh_pkg for entry_t and pick_t

module tnh_pick (
    input  tnh_pkg::entry_t left,
    input  tnh_pkg::entry_t right,
    input  logic right_ok,
    input  logic signed [tnh_pkg::VALUE_W-1:0] item_value,
    output tnh_pkg::pick_t pick
);

    logic signed [tnh_pkg::VALUE_W-1:0] pick_value;

    always_comb
    begin
        if (!right_ok)
        begin
            pick.take_right = 1'b0;
        end
        else if (left.value == right.value)
        begin
            // equal values: newer stamp wins
            pick.take_right = !(left.stamp > right.stamp);
        end
        else
        begin
            pick.take_right = !(left.value < right.value);
        end
        pick_value = pick.take_right ? right.value : left.value;
        pick.stop = item_value < pick_value;
    end

endmodule

[hdl/top_n_heap_tracker.sv]
// top_n_heap_tracker: top level, sift-down sequencer around the heap memory
// depends on tnh_pkg, tnh_heap_mem and tnh_pick

// Keeps the HEAP_SIZE largest values with their stamps in a min-heap held in
// one memory with two read ports and one write port. After reset the block
// zeroes the memory, one slot a cycle, and takes no item meanwhile. One item
// is worked at a time. A read or an ignored insert reads the root or slot at
// acceptance and finishes in the root state. An accepted insert then descends
// level by level: each level returns both children from the memory, compares
// them and writes one entry back, plus one more write when it reaches a leaf.
// The result sits in an output register; a result that finds that register
// still stalled waits in the put state, and no item is accepted until it is
// passed on.

module top_n_heap_tracker #(
    parameter int HEAP_SIZE = tnh_pkg::HEAP_SIZE_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic mode,
    input  logic signed [tnh_pkg::VALUE_W-1:0] value,
    input  logic [tnh_pkg::STAMP_W-1:0] stamp,
    input  logic [tnh_pkg::SLOT_W-1:0] slot,
    output logic out_valid,
    input  logic out_stall,
    output logic accepted,
    output logic signed [tnh_pkg::VALUE_W-1:0] entry_value,
    output logic [tnh_pkg::STAMP_W-1:0] entry_stamp
);

    localparam int AW = $clog2(HEAP_SIZE);
    localparam int CW = AW + 2;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_PUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic right_ok_reg, right_ok_next;
    logic mode_reg;
    logic slot_ok_reg;
    tnh_pkg::entry_t item_reg;

    logic out_valid_reg, out_valid_next;
    logic acc_out_reg;
    tnh_pkg::entry_t ent_out_reg;
    logic pend_acc_reg;
    tnh_pkg::entry_t pend_ent_reg;

    logic we;
    logic [AW-1:0] waddr;
    tnh_pkg::entry_t wdata;
    logic [AW-1:0] raddr_a, raddr_b;
    tnh_pkg::entry_t rdata_a, rdata_b;

    tnh_pkg::pick_t pick;
    logic in_fire;
    logic out_free;
    logic fin;
    logic fin_acc;
    tnh_pkg::entry_t fin_ent;
    logic [31:0] slot_wide;
    logic slot_ok;
    logic [CW-1:0] cur_left, cur_right, root_left, root_right;
    logic [CW-1:0] pick_idx, pick_left, pick_right;

    tnh_heap_mem #(
        .DEPTH(HEAP_SIZE),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr_a(raddr_a),
        .rdata_a(rdata_a),
        .raddr_b(raddr_b),
        .rdata_b(rdata_b)
    );

    tnh_pick u_pick (
        .left(rdata_a),
        .right(rdata_b),
        .right_ok(right_ok_reg),
        .item_value(item_reg.value),
        .pick(pick)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign slot_wide = 32'(slot);
    assign slot_ok = slot_wide < 32'(HEAP_SIZE);

    assign root_left = CW'(1);
    assign root_right = CW'(2);
    assign cur_left = CW'({cur_reg, 1'b1});
    assign cur_right = cur_left + CW'(1);
    assign pick_idx = pick.take_right ? cur_right : cur_left;
    assign pick_left = CW'({pick_idx[AW-1:0], 1'b1});
    assign pick_right = pick_left + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cur_next = cur_reg;
        right_ok_next = right_ok_reg;
        we = 1'b0;
        waddr = cur_reg;
        wdata = item_reg;
        raddr_a = '0;
        raddr_b = '0;
        fin = 1'b0;
        fin_acc = 1'b0;
        fin_ent = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(HEAP_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                raddr_a = mode ? slot_wide[AW-1:0] : '0;
                if (in_fire)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (mode_reg)
                begin
                    fin = 1'b1;
                    fin_ent = slot_ok_reg ? rdata_a : '0;
                end
                else if (item_reg.value < rdata_a.value)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    // new entry takes the root, look at its children
                    cur_next = '0;
                    raddr_a = root_left[AW-1:0];
                    raddr_b = root_right[AW-1:0];
                    right_ok_next = root_right < CW'(HEAP_SIZE);
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                we = 1'b1;
                waddr = cur_reg;
                if (pick.stop)
                begin
                    wdata = item_reg;
                    fin = 1'b1;
                    fin_acc = 1'b1;
                end
                else
                begin
                    wdata = pick.take_right ? rdata_b : rdata_a;
                    cur_next = pick_idx[AW-1:0];
                    raddr_a = pick_left[AW-1:0];
                    raddr_b = pick_right[AW-1:0];
                    right_ok_next = pick_right < CW'(HEAP_SIZE);
                    if (pick_left < CW'(HEAP_SIZE))
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                we = 1'b1;
                waddr = cur_reg;
                wdata = item_reg;
                fin = 1'b1;
                fin_acc = 1'b1;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_PUT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((fin || state_reg == S_PUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cur_reg <= '0;
            right_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            cur_reg <= cur_next;
            right_ok_reg <= right_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode;
            slot_ok_reg <= slot_ok;
            item_reg.value <= value;
            item_reg.stamp <= stamp;
        end
        if (fin)
        begin
            pend_acc_reg <= fin_acc;
            pend_ent_reg <= fin_ent;
        end
        if (fin && out_free)
        begin
            acc_out_reg <= fin_acc;
            ent_out_reg <= fin_ent;
        end
        else if (state_reg == S_PUT && out_free)
        begin
            acc_out_reg <= pend_acc_reg;
            ent_out_reg <= pend_ent_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted = acc_out_reg;
    assign entry_value = ent_out_reg.value;
    assign entry_stamp = ent_out_reg.stamp;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (32'(waddr) < 32'(HEAP_SIZE)))
        else $error("heap write outside heap");

    a_accept_reads_root: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_ROOT))
        else $error("accepted item did not go to root read");

    a_eval_has_child: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (cur_left < CW'(HEAP_SIZE)))
        else $error("sift level without a child");

    a_descend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && !pick.stop) |=> (cur_reg > $past(cur_reg)))
        else $error("sift did not move down");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(ent_out_reg)
            && $stable(acc_out_reg)))
        else $error("waiting result overwritten");

endmodule
